>>> rtl/core/lsf_pkg.sv
// Shared types, codes and defaults for the LPC synthesis filter unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int ORDER_DEF     = 16;  // predictor order
  localparam int COEF_FRAC_DEF = 12;  // fraction bits of a coefficient

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 4;

  // Kind of an input transfer.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FILTER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_EMIT
  } lsf_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // write one coefficient
    logic start;  // latch excitation, clear accumulator, maybe clear history
    logic mac;    // one multiply-accumulate step
    logic round;  // negate and round the sum
    logic emit;   // saturate, write output register, push history
  } lsf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mac_done;  // last product is being accumulated
    logic out_free;  // output register can take a result this cycle
  } lsf_sts_t;

endpackage

>>> rtl/core/lsf_ctrl.sv
// Sequencer for the LPC synthesis filter unit: accept, MAC sweep, round, emit.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              action,
  input  lsf_pkg::lsf_sts_t sts,
  output lsf_pkg::lsf_cmd_t cmd
);
  import lsf_pkg::*;

  lsf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && action == ACT_FILTER) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (sts.mac_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && action == ACT_LOAD;
        cmd.start = in_tvalid && action == ACT_FILTER;
      end
      ST_MAC:   cmd.mac = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_EMIT:  cmd.emit = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start, cmd.mac, cmd.round, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register is occupied");

  a_start_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_MAC) && !in_tready)
    else $error("filter transfer did not start the MAC sweep");

endmodule

>>> rtl/core/lsf_dp.sv
// Datapath of the LPC synthesis filter unit: coefficient and history registers,
// shared multiplier, accumulator, rounding, saturation, output register. Uses lsf_pkg.
`timescale 1ns / 1ps

module lsf_dp #(
  parameter int ORDER     = lsf_pkg::ORDER_DEF,
  parameter int COEF_FRAC = lsf_pkg::COEF_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lsf_pkg::lsf_cmd_t                   cmd,
  output lsf_pkg::lsf_sts_t                   sts,
  input  logic        [lsf_pkg::CIDX_W-1:0]   coef_index,
  input  logic signed [lsf_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [lsf_pkg::SAMPLE_W-1:0] excitation,
  input  logic                                frame_start,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [lsf_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_clipped
);
  import lsf_pkg::*;

  localparam int IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CNT_W  = $clog2(ORDER + 1);
  localparam int CI_W   = (IDX_W > CIDX_W) ? IDX_W : CIDX_W;
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(ORDER);
  localparam int RND_W  = ACC_W + 1 - COEF_FRAC;
  localparam int TOT_W  = RND_W + 1;

  localparam logic signed [ACC_W:0]   HALF    = (ACC_W + 1)'(1) << (COEF_FRAC - 1);
  localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(32767);
  localparam logic signed [TOT_W-1:0] SAT_MIN = TOT_W'(-32768);

  logic signed [COEF_W-1:0]   coef_r [ORDER];
  logic signed [SAMPLE_W-1:0] hist_r [ORDER];
  logic signed [COEF_W-1:0]   coef_nxt [ORDER];
  logic signed [SAMPLE_W-1:0] hist_nxt [ORDER];

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       prod_vld_r, prod_vld_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [RND_W-1:0]    rnd_r, rnd_nxt;
  logic signed [SAMPLE_W-1:0] exc_r, exc_nxt;
  logic                       out_vld_r, out_vld_nxt;
  logic signed [SAMPLE_W-1:0] samp_r, samp_nxt;
  logic                       clip_r, clip_nxt;

  logic [CI_W-1:0]            cidx_ext;
  logic [IDX_W-1:0]           tap;
  logic                       tap_ok;
  logic signed [COEF_W-1:0]   tap_coef;
  logic signed [SAMPLE_W-1:0] tap_hist;
  logic signed [ACC_W:0]      neg_acc;
  logic signed [TOT_W-1:0]    total;
  logic signed [SAMPLE_W-1:0] y;
  logic                       clip;

  assign cidx_ext = CI_W'(coef_index);
  assign tap      = cnt_r[IDX_W-1:0];
  assign tap_ok   = cnt_r < CNT_W'(ORDER);
  assign tap_coef = tap_ok ? coef_r[tap] : '0;
  assign tap_hist = tap_ok ? hist_r[tap] : '0;

  // -acc + half, floor shift by the fraction bits (ties toward plus infinity)
  assign neg_acc = HALF - {acc_r[ACC_W-1], acc_r};

  always_comb begin
    total = {rnd_r[RND_W-1], rnd_r} + TOT_W'(exc_r);
    clip  = 1'b0;
    y     = total[SAMPLE_W-1:0];
    if (total > SAT_MAX) begin
      y    = SAMPLE_W'(32767);
      clip = 1'b1;
    end else if (total < SAT_MIN) begin
      y    = SAMPLE_W'(-32768);
      clip = 1'b1;
    end
  end

  always_comb begin
    coef_nxt     = coef_r;
    hist_nxt     = hist_r;
    cnt_nxt      = cnt_r;
    prod_vld_nxt = prod_vld_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    rnd_nxt      = rnd_r;
    exc_nxt      = exc_r;
    samp_nxt     = samp_r;
    clip_nxt     = clip_r;
    out_vld_nxt  = out_vld_r && !out_tready;

    if (cmd.load) begin
      for (int i = 0; i < ORDER; i++) begin
        if (cidx_ext == CI_W'(i)) coef_nxt[i] = coef_value;
      end
    end

    if (cmd.start) begin
      exc_nxt      = excitation;
      cnt_nxt      = '0;
      acc_nxt      = '0;
      prod_vld_nxt = 1'b0;
      if (frame_start) begin
        for (int i = 0; i < ORDER; i++) hist_nxt[i] = '0;
      end
    end

    // product registered, then accumulated in the following cycle
    if (cmd.mac) begin
      prod_nxt     = PROD_W'(tap_coef * tap_hist);
      prod_vld_nxt = tap_ok;
      if (tap_ok) cnt_nxt = cnt_r + CNT_W'(1);
      if (prod_vld_r) acc_nxt = acc_r + ACC_W'(prod_r);
    end

    if (cmd.round) rnd_nxt = neg_acc[ACC_W:COEF_FRAC];

    if (cmd.emit) begin
      samp_nxt    = y;
      clip_nxt    = clip;
      out_vld_nxt = 1'b1;
      for (int i = ORDER - 1; i > 0; i--) hist_nxt[i] = hist_r[i-1];
      hist_nxt[0] = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORDER; i++) begin
        coef_r[i] <= '0;
        hist_r[i] <= '0;
      end
      cnt_r      <= '0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      coef_r     <= coef_nxt;
      hist_r     <= hist_nxt;
      cnt_r      <= cnt_nxt;
      prod_vld_r <= prod_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rnd_r  <= rnd_nxt;
    exc_r  <= exc_nxt;
    samp_r <= samp_nxt;
    clip_r <= clip_nxt;
  end

  assign sts.mac_done = cmd.mac && (cnt_r == CNT_W'(ORDER));
  assign sts.out_free = !out_vld_r || out_tready;

  assign out_tvalid  = out_vld_r;
  assign out_sample  = samp_r;
  assign out_clipped = clip_r;

  a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> !prod_vld_r && cnt_r == CNT_W'(ORDER))
    else $error("rounding before the last product was accumulated");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && frame_start) |=> hist_r[0] == '0 && hist_r[ORDER-1] == '0)
    else $error("frame start did not clear the output history");

  a_emit_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_vld_r && hist_r[0] == samp_r)
    else $error("emitted sample not pushed into history");

endmodule

>>> rtl/core/lpc_synthesis_filter_unit.sv
// Top level of the order-16 all-pole LPC synthesis filter.
// Instantiates lsf_ctrl (sequencer) and lsf_dp (datapath); uses lsf_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream (in_*): in_tuser[0] selects the kind of transfer.
//     Load transfer: writes in_tdata coef_value into coefficient slot coef_index
//     (ignored if the index is not below ORDER). Produces no output.
//     Filter transfer: filters the excitation sample. in_tuser[1] marks the
//     first sample of a frame; the output history counts as zero for it.
//   Output stream (out_*): one transfer per filter transfer, carrying the
//     saturated sample in out_tdata and the clip flag in out_tuser.
//   Timing: a load is written at the accepting edge. A filter transfer runs
//     the MAC sweep on the single shared 16x16 multiplier and accumulator
//     (one tap per cycle, then a drain of the product register), then the
//     rounding step and the saturation/emit step, after which out_tvalid
//     rises. in_tready is high only in idle, which follows the emit cycle,
//     so a new filter transfer is accepted only after the previous sample
//     has been emitted.
//   Stall: the result sits in an output register; the next item is accepted
//     while it waits. A following result holds in the emit step until the
//     register is taken.
//   Reset (rst_n low, synchronous): coefficients and history clear to zero,
//     output channel empties, sequencer returns to idle.

module lpc_synthesis_filter_unit #(
  parameter int ORDER     = lsf_pkg::ORDER_DEF,
  parameter int COEF_FRAC = lsf_pkg::COEF_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] coef_index, [19:4] coef_value,
                                  // [35:20] excitation, [39:36] zero
  input  logic [1:0]  in_tuser,   // [0] action, [1] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample
  output logic        out_tuser   // [0] clipped
);
  import lsf_pkg::*;

  lsf_cmd_t cmd;
  lsf_sts_t sts;

  logic        [CIDX_W-1:0]   coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] excitation;
  logic signed [SAMPLE_W-1:0] sample;

  // Field unpacking of the input transfer
  assign coef_index = in_tdata[3:0];
  assign coef_value = in_tdata[19:4];
  assign excitation = in_tdata[35:20];

  lsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .action    (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsf_dp #(
    .ORDER     (ORDER),
    .COEF_FRAC (COEF_FRAC)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .excitation  (excitation),
    .frame_start (in_tuser[1]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_sample  (sample),
    .out_clipped (out_tuser)
  );

  assign out_tdata = sample;

endmodule
